### design/mseq_pkg.sv
// ----------------------------------------------------------------------------
// mseq_pkg: shared types and constants of the queue event engine
// Holds the command and status words between the controller and the datapath,
// the operation codes and the reset value of the server-count register.
// ----------------------------------------------------------------------------
package mseq_pkg;

	// Default size of the server table.
	localparam int SERVER_COUNT_DEF = 32;

	// Width and reset value of the active server register.
	localparam int ACTIVE_W = 6;
	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 6'd20;

	// Operation codes of an input word.
	localparam logic OP_ARRIVAL   = 1'b0;
	localparam logic OP_DEPARTURE = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_item;  // capture the accepted input word
		logic scan_clr;   // clear the running minimum
		logic rd_en;      // read one table entry at the scan address
		logic pass2;      // second scan: always search busy servers
		logic adv;        // pick the event time and the elapsed ticks
		logic mul;        // form elapsed ticks times jobs in node
		logic commit;     // update counters, area and the server table
		logic load_out;   // load the result register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic found;      // the running minimum holds a candidate
		logic op;         // operation of the word in work
	} sts_t;

endpackage

### design/multi_server_queue_event_engine_top.sv
// The engine works on one word at a time: each word takes two scans of the server
// table through its single read port, one entry per cycle, and a new word is taken
// only after the result of the last one has been loaded into the output register.
// A result may wait in the output register; the next word is taken meanwhile.
// Reset (arst_n low) clears all servers to idle, times, counters and area to zero,
// and active_servers to 20; no clearing pass is needed.
// ----------------------------------------------------------------------------
// multi_server_queue_event_engine_top: event engine of a multi-server queue
// Takes arrival and departure words, assigns jobs to servers or the waiting
// queue, and reports the next completion, counters and occupancy area.
// ----------------------------------------------------------------------------
module multi_server_queue_event_engine_top import mseq_pkg::*; #(
	parameter int SERVER_COUNT = SERVER_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [ACTIVE_W-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                operation,
	input  logic [31:0]         arrival_time,
	input  logic [31:0]         service_time,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                next_valid,
	output logic [31:0]         next_completion,
	output logic [4:0]          departed_server,
	output logic [31:0]         departure_instant,
	output logic [31:0]         jobs_in_node,
	output logic [31:0]         waiting_jobs,
	output logic [31:0]         completed_jobs,
	output logic [63:0]         occupancy_area
);

	localparam int IW = $clog2(SERVER_COUNT);

	cmd_t          cmd;
	sts_t          sts;
	logic [IW-1:0] rd_addr;

	// The register write is taken in any cycle.
	assign cfg_ready = 1'b1;

	mseq_ctrl #(
		.SERVER_COUNT(SERVER_COUNT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd),
		.rd_addr  (rd_addr)
	);

	mseq_dpath #(
		.SERVER_COUNT(SERVER_COUNT)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.operation        (operation),
		.arrival_time     (arrival_time),
		.service_time     (service_time),
		.cfg_we           (cfg_valid && cfg_ready),
		.cfg_data         (cfg_data),
		.cmd              (cmd),
		.rd_addr          (rd_addr),
		.sts              (sts),
		.next_valid       (next_valid),
		.next_completion  (next_completion),
		.departed_server  (departed_server),
		.departure_instant(departure_instant),
		.jobs_in_node     (jobs_in_node),
		.waiting_jobs     (waiting_jobs),
		.completed_jobs   (completed_jobs),
		.occupancy_area   (occupancy_area)
	);

endmodule

### design/mseq_ctrl.sv
// ----------------------------------------------------------------------------
// mseq_ctrl: sequencer of the queue event engine
// Steps one event through a table scan, the clock advance, the state update
// and a second scan for the next completion, then hands the result off.
// ----------------------------------------------------------------------------
module mseq_ctrl import mseq_pkg::*; #(
	parameter int SERVER_COUNT = SERVER_COUNT_DEF,
	localparam int IW = $clog2(SERVER_COUNT)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  sts_t          sts,
	output cmd_t          cmd,
	output logic [IW-1:0] rd_addr
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_SCAN1  = 4'd1;
	localparam logic [3:0] ST_DRAIN1 = 4'd2;
	localparam logic [3:0] ST_ADV    = 4'd3;
	localparam logic [3:0] ST_MUL    = 4'd4;
	localparam logic [3:0] ST_COMMIT = 4'd5;
	localparam logic [3:0] ST_SCAN2  = 4'd6;
	localparam logic [3:0] ST_DRAIN2 = 4'd7;
	localparam logic [3:0] ST_OUT    = 4'd8;

	localparam logic [IW-1:0] LAST_IDX = IW'(SERVER_COUNT - 1);

	logic [3:0]    state_q;
	logic [3:0]    state_d;
	logic [IW-1:0] cnt_q;
	logic          out_valid_q;
	logic          accept;
	logic          scan_last;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign rd_addr   = cnt_q;
	assign scan_last = (cnt_q == LAST_IDX);

	// Command decode and next state.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load_item = 1'b1;
					cmd.scan_clr  = 1'b1;
					state_d       = ST_SCAN1;
				end
			end
			ST_SCAN1: begin
				cmd.rd_en = 1'b1;
				if (scan_last) begin
					state_d = ST_DRAIN1;
				end
			end
			ST_DRAIN1: begin
				state_d = ST_ADV;
			end
			ST_ADV: begin
				cmd.adv = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				// A departure with no busy server leaves the state alone.
				cmd.commit   = (sts.op == OP_ARRIVAL) || sts.found;
				cmd.scan_clr = 1'b1;
				state_d      = ST_SCAN2;
			end
			ST_SCAN2: begin
				cmd.rd_en = 1'b1;
				cmd.pass2 = 1'b1;
				if (scan_last) begin
					state_d = ST_DRAIN2;
				end
			end
			ST_DRAIN2: begin
				cmd.pass2 = 1'b1;
				state_d   = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State, scan counter and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.rd_en) begin
				cnt_q <= scan_last ? '0 : cnt_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// An accepted word starts the first scan at entry zero.
	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_SCAN1 && cnt_q == '0))
		else $error("accepted word did not start a scan at entry zero");

	// The scan drains only after reading the last entry.
	a_drain_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN1) |-> ($past(state_q) == ST_SCAN1 && $past(cnt_q) == LAST_IDX))
		else $error("scan drained before the last entry");

	// A held result is never replaced by the next one.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_valid_q && !out_ready) |=> (state_q == ST_OUT))
		else $error("result register overwritten while held");

endmodule

### design/mseq_dpath.sv
// ----------------------------------------------------------------------------
// mseq_dpath: datapath of the queue event engine
// Holds the server table, the busy flags, the clock, the counters and the
// occupancy area, the scan comparator and the result register.
// ----------------------------------------------------------------------------
module mseq_dpath import mseq_pkg::*; #(
	parameter int SERVER_COUNT = SERVER_COUNT_DEF,
	localparam int IW = $clog2(SERVER_COUNT)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                operation,
	input  logic [31:0]         arrival_time,
	input  logic [31:0]         service_time,
	input  logic                cfg_we,
	input  logic [ACTIVE_W-1:0] cfg_data,
	input  cmd_t                cmd,
	input  logic [IW-1:0]       rd_addr,
	output sts_t                sts,
	output logic                next_valid,
	output logic [31:0]         next_completion,
	output logic [4:0]          departed_server,
	output logic [31:0]         departure_instant,
	output logic [31:0]         jobs_in_node,
	output logic [31:0]         waiting_jobs,
	output logic [31:0]         completed_jobs,
	output logic [63:0]         occupancy_area
);

	localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? MAX32 : s[31:0];
	endfunction

	function automatic logic [31:0] sat_inc32(input logic [31:0] a);
		return (a == MAX32) ? a : a + 32'd1;
	endfunction

	function automatic logic [31:0] sat_dec32(input logic [31:0] a);
		return (a == 32'd0) ? a : a - 32'd1;
	endfunction

	// Captured input word.
	logic        op_q;
	logic [31:0] arr_q;
	logic [31:0] svc_q;

	// Engine state.
	logic [ACTIVE_W-1:0]     active_q;
	logic [31:0]             time_mem [SERVER_COUNT];
	logic [SERVER_COUNT-1:0] written_q;
	logic [SERVER_COUNT-1:0] busy_q;
	logic [31:0]             clock_q;
	logic [31:0]             node_q;
	logic [31:0]             queue_q;
	logic [31:0]             done_q;
	logic [63:0]             area_q;

	// Scan read stage and running minimum.
	logic          rd_vld_s1;
	logic [IW-1:0] rd_idx_s1;
	logic [31:0]   rd_data_s1;
	logic          rd_busy_s1;
	logic          rd_wr_s1;
	logic          found_q;
	logic [31:0]   best_time_q;
	logic [IW-1:0] best_idx_q;

	// Event registers.
	logic          evt_q;
	logic [31:0]   evt_t_q;
	logic [IW-1:0] tgt_idx_q;
	logic          tgt_found_q;
	logic [31:0]   elapsed_q;
	logic [IW-1:0] dep_idx_q;
	logic [31:0]   dep_time_q;
	logic [63:0]   prod_q;

	logic [31:0] rd_time;
	logic        rd_up;
	logic        busy_mode;
	logic        cand;
	logic [31:0] evt_t;
	logic        tgt_up;
	logic        wr_en;
	logic [31:0] wr_data;
	logic [64:0] area_sum;

	assign sts.found = found_q;
	assign sts.op    = op_q;

	// An entry never written reads as zero.
	assign rd_time   = rd_wr_s1 ? rd_data_s1 : 32'd0;
	assign rd_up     = (7'(rd_idx_s1) < 7'(active_q));
	assign busy_mode = cmd.pass2 || (op_q == OP_DEPARTURE);
	assign cand      = busy_mode ? rd_busy_s1 : (!rd_busy_s1 && rd_up);
	assign evt_t     = (op_q == OP_ARRIVAL) ? arr_q : best_time_q;

	// Table write: an arrival onto an idle server, or a departure restarting.
	assign tgt_up  = (7'(tgt_idx_q) < 7'(active_q));
	assign wr_data = sat_add32(evt_t_q, svc_q);
	assign wr_en   = cmd.commit && evt_q && tgt_found_q &&
		((op_q == OP_ARRIVAL) || (queue_q != 32'd0 && tgt_up));

	assign area_sum = {1'b0, area_q} + {1'b0, prod_q};

	// Input capture and event payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q  <= operation;
			arr_q <= arrival_time;
			svc_q <= service_time;
		end
		if (cmd.adv) begin
			evt_t_q     <= evt_t;
			tgt_idx_q   <= best_idx_q;
			tgt_found_q <= found_q;
			elapsed_q   <= (evt_t >= clock_q) ? evt_t - clock_q : 32'd0;
			dep_idx_q   <= (op_q == OP_DEPARTURE && found_q) ? best_idx_q : '0;
			dep_time_q  <= (op_q == OP_DEPARTURE && found_q) ? best_time_q : 32'd0;
		end
		if (cmd.mul) begin
			prod_q <= elapsed_q * node_q;
		end
	end

	// Server table memory with registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			time_mem[tgt_idx_q] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= time_mem[rd_addr];
			rd_idx_s1  <= rd_addr;
			rd_busy_s1 <= busy_q[rd_addr];
			rd_wr_s1   <= written_q[rd_addr];
		end
	end

	// Running minimum over the scan; ties keep the lower index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
			if (cmd.scan_clr) begin
				found_q <= 1'b0;
			end else if (rd_vld_s1 && cand && (!found_q || rd_time < best_time_q)) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd.scan_clr && rd_vld_s1 && cand && (!found_q || rd_time < best_time_q)) begin
			best_time_q <= rd_time;
			best_idx_q  <= rd_idx_s1;
		end
	end

	// Configuration, counters, area, clock and busy flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= ACTIVE_RESET;
			written_q <= '0;
			busy_q    <= '0;
			clock_q   <= 32'd0;
			node_q    <= 32'd0;
			queue_q   <= 32'd0;
			done_q    <= 32'd0;
			area_q    <= 64'd0;
			evt_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				active_q <= cfg_data;
			end
			if (cmd.adv) begin
				evt_q <= (op_q == OP_ARRIVAL) || found_q;
			end
			if (wr_en) begin
				written_q[tgt_idx_q] <= 1'b1;
			end
			if (cmd.commit && evt_q) begin
				clock_q <= evt_t_q;
				area_q  <= area_sum[64] ? {64{1'b1}} : area_sum[63:0];
				if (op_q == OP_ARRIVAL) begin
					node_q <= sat_inc32(node_q);
					if (tgt_found_q) begin
						busy_q[tgt_idx_q] <= 1'b1;
					end else begin
						queue_q <= sat_inc32(queue_q);
					end
				end else begin
					done_q <= sat_inc32(done_q);
					node_q <= sat_dec32(node_q);
					if (queue_q != 32'd0 && tgt_up) begin
						queue_q <= queue_q - 32'd1;
					end else begin
						busy_q[tgt_idx_q] <= 1'b0;
					end
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			next_valid        <= found_q;
			next_completion   <= found_q ? best_time_q : 32'd0;
			departed_server   <= 5'(dep_idx_q);
			departure_instant <= dep_time_q;
			jobs_in_node      <= node_q;
			waiting_jobs      <= queue_q;
			completed_jobs    <= done_q;
			occupancy_area    <= area_q;
		end
	end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the multi-server queue event engine
// Drives arrival and departure words through the valid/ready input channel,
// predicts every event report with an in-bench model of the server table,
// counters and occupancy area, and checks each report field by field.
// Covers corner cases, server-count changes, random traffic under several
// idle patterns, and a long output stall that fills the engine.
// ----------------------------------------------------------------------------
module tb_top;
	import mseq_pkg::*;

	localparam int NUM_SERVERS    = SERVER_COUNT_DEF;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 2 * NUM_SERVERS + 30;

	// One input word and one event report.
	typedef struct packed {
		logic        op;
		logic [31:0] arr;
		logic [31:0] svc;
	} event_word_t;

	typedef struct packed {
		logic        next_valid;
		logic [31:0] next_completion;
		logic [4:0]  departed_server;
		logic [31:0] departure_instant;
		logic [31:0] jobs_in_node;
		logic [31:0] waiting_jobs;
		logic [31:0] completed_jobs;
		logic [63:0] occupancy_area;
	} event_report_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [ACTIVE_W-1:0] cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                operation = OP_ARRIVAL;
	logic [31:0]         arrival_time = '0;
	logic [31:0]         service_time = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                next_valid;
	logic [31:0]         next_completion;
	logic [4:0]          departed_server;
	logic [31:0]         departure_instant;
	logic [31:0]         jobs_in_node;
	logic [31:0]         waiting_jobs;
	logic [31:0]         completed_jobs;
	logic [63:0]         occupancy_area;

	// Predicted engine state.
	bit [31:0]           srv_time [NUM_SERVERS];
	bit                  srv_busy [NUM_SERVERS];
	bit [31:0]           now_ticks;
	bit [31:0]           jobs_cnt;
	bit [31:0]           queued_cnt;
	bit [31:0]           done_cnt;
	bit [63:0]           area_acc;
	bit [ACTIVE_W-1:0]   active_cfg = ACTIVE_RESET;

	event_report_t       awaited_reports [$];
	int                  fail_count = 0;
	int                  send_idle_pct = 0;
	int                  recv_idle_pct = 0;
	int                  hold_len = 0;
	int                  quiet_cycles = 0;

	multi_server_queue_event_engine_top u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.operation         (operation),
		.arrival_time      (arrival_time),
		.service_time      (service_time),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.next_valid        (next_valid),
		.next_completion   (next_completion),
		.departed_server   (departed_server),
		.departure_instant (departure_instant),
		.jobs_in_node      (jobs_in_node),
		.waiting_jobs      (waiting_jobs),
		.completed_jobs    (completed_jobs),
		.occupancy_area    (occupancy_area)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Prediction of the engine
	// ------------------------------------------------------------------

	function automatic bit [31:0] sat_sum(bit [31:0] a, bit [31:0] b);
		bit [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic bit [31:0] sat_inc(bit [31:0] a);
		return (a == 32'hFFFF_FFFF) ? a : a + 32'd1;
	endfunction

	// Busy server that completes first; the lowest index wins a tie.
	function automatic int earliest_busy();
		int best;
		best = -1;
		for (int i = 0; i < NUM_SERVERS; i++) begin
			if (srv_busy[i] && (best < 0 || srv_time[i] < srv_time[best]))
				best = i;
		end
		return best;
	endfunction

	// Up, idle server that has been idle longest; the lowest index wins a tie.
	function automatic int longest_idle();
		int best;
		best = -1;
		for (int i = 0; i < NUM_SERVERS; i++) begin
			if (i < int'(active_cfg) && !srv_busy[i] &&
			    (best < 0 || srv_time[i] < srv_time[best]))
				best = i;
		end
		return best;
	endfunction

	function automatic int busy_count();
		int n;
		n = 0;
		for (int i = 0; i < NUM_SERVERS; i++)
			n += srv_busy[i];
		return n;
	endfunction

	// Move the clock to the event time and add elapsed ticks times jobs in node.
	function automatic void advance_to(bit [31:0] t);
		bit [31:0] elapsed;
		bit [64:0] s;
		elapsed = (t >= now_ticks) ? t - now_ticks : 32'd0;
		s = {1'b0, area_acc} + {1'b0, 64'(elapsed) * 64'(jobs_cnt)};
		area_acc = s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
		now_ticks = t;
	endfunction

	// Apply one accepted word to the model and return the report it causes.
	function automatic event_report_t predict_event(event_word_t w);
		event_report_t r;
		int            s;
		int            e;
		int            n;
		bit [31:0]     t;
		r = '0;
		if (w.op == OP_ARRIVAL) begin
			advance_to(w.arr);
			jobs_cnt = sat_inc(jobs_cnt);
			s = longest_idle();
			if (s >= 0) begin
				srv_time[s] = sat_sum(now_ticks, w.svc);
				srv_busy[s] = 1'b1;
			end else begin
				queued_cnt = sat_inc(queued_cnt);
			end
		end else begin
			e = earliest_busy();
			// A departure with nothing in service leaves the state alone.
			if (e >= 0) begin
				t = srv_time[e];
				advance_to(t);
				done_cnt = sat_inc(done_cnt);
				jobs_cnt = (jobs_cnt == 0) ? 32'd0 : jobs_cnt - 32'd1;
				r.departed_server = e[4:0];
				r.departure_instant = t;
				if (queued_cnt > 0 && e < int'(active_cfg)) begin
					queued_cnt--;
					srv_time[e] = sat_sum(now_ticks, w.svc);
				end else begin
					srv_busy[e] = 1'b0;
				end
			end
		end
		n = earliest_busy();
		r.next_valid = (n >= 0);
		r.next_completion = (n >= 0) ? srv_time[n] : 32'd0;
		r.jobs_in_node = jobs_cnt;
		r.waiting_jobs = queued_cnt;
		r.completed_jobs = done_cnt;
		r.occupancy_area = area_acc;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Report checking
	// ------------------------------------------------------------------

	function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// Each accepted report is matched against the oldest prediction.
	always @(posedge clk) begin
		event_report_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_reports.size() == 0) begin
				$display("%0t: report word with no prediction waiting", $time);
				fail_count++;
			end else begin
				want = awaited_reports.pop_front();
				compare_field("next_valid", want.next_valid, next_valid);
				compare_field("next_completion", want.next_completion, next_completion);
				compare_field("departed_server", want.departed_server, departed_server);
				compare_field("departure_instant", want.departure_instant, departure_instant);
				compare_field("jobs_in_node", want.jobs_in_node, jobs_in_node);
				compare_field("waiting_jobs", want.waiting_jobs, waiting_jobs);
				compare_field("completed_jobs", want.completed_jobs, completed_jobs);
				compare_field("occupancy_area", want.occupancy_area, occupancy_area);
			end
		end
	end

	// Receiver: random stalls, or a long hold-off when one is requested.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				out_ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog: ends the run when no word moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no word accepted for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	// Offer one word, hold it until accepted, and record its prediction.
	task automatic send_event(bit op, bit [31:0] arr, bit [31:0] svc);
		event_word_t w;
		int          gap;
		w = '{op: op, arr: arr, svc: svc};
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (send_idle_pct > 0 && $urandom_range(19) == 0)
			gap += $urandom_range(1, 80);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		arrival_time <= arr;
		service_time <= svc;
		do @(posedge clk); while (!in_ready);
		awaited_reports.push_back(predict_event(w));
	endtask

	// Stop offering words and wait until every report has come back.
	task automatic quiesce();
		in_valid <= 1'b0;
		do @(posedge clk); while (awaited_reports.size() != 0);
	endtask

	// Write the server-count register while the engine is idle.
	task automatic write_active(bit [ACTIVE_W-1:0] value);
		quiesce();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		active_cfg = value;
		cfg_valid <= 1'b0;
	endtask

	// Complete busy servers until none is left in service.
	task automatic depart_until_idle(bit [31:0] svc);
		while (earliest_busy() >= 0)
			send_event(OP_DEPARTURE, $urandom, svc);
	endtask

	// Corner cases at the reset server count.
	task automatic test_corner_events();
		// Departure with nothing in service is ignored.
		send_event(OP_DEPARTURE, 32'hFFFF_FFFF, 32'd5);
		send_event(OP_ARRIVAL, 32'd0, 32'd0);
		// Two jobs that finish together.
		send_event(OP_ARRIVAL, 32'd100, 32'd50);
		send_event(OP_ARRIVAL, 32'd100, 32'd50);
		// Completion time behind the clock, then a tie in completion.
		send_event(OP_DEPARTURE, 32'd0, 32'd0);
		send_event(OP_DEPARTURE, 32'd0, 32'd0);
		// Completion times that overflow and saturate.
		send_event(OP_ARRIVAL, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
		send_event(OP_ARRIVAL, 32'd7, 32'hFFFF_FFFF);
		send_event(OP_ARRIVAL, 32'hFFFF_FFFF, 32'd0);
		depart_until_idle(32'd1);
	endtask

	// Queueing, restart from the queue, and server-count changes.
	task automatic test_server_count_changes();
		write_active(6'd1);
		send_event(OP_ARRIVAL, 32'd10, 32'd20);
		send_event(OP_ARRIVAL, 32'd12, 32'd5);
		send_event(OP_ARRIVAL, 32'd14, 32'd5);
		send_event(OP_DEPARTURE, 32'd0, 32'd7);
		// No server up: the busy one finishes and goes idle, arrivals queue.
		write_active(6'd0);
		send_event(OP_DEPARTURE, 32'd0, 32'd9);
		send_event(OP_ARRIVAL, 32'd40, 32'd3);
		send_event(OP_DEPARTURE, 32'd0, 32'd9);
		// A value above the table size brings every server up.
		write_active(6'd63);
		send_event(OP_ARRIVAL, 32'd50, 32'd3);
		send_event(OP_ARRIVAL, 32'd51, 32'd4);
		depart_until_idle(32'd2);
	endtask

	// Random traffic: mostly well-formed events near the clock, some noise.
	task automatic run_traffic(int count);
		int        counted;
		int        busy_n;
		int        up_n;
		bit        op;
		bit [31:0] arr;
		bit [31:0] svc;
		bit [31:0] base;
		counted = 0;
		while (counted < count) begin
			busy_n = busy_count();
			up_n = (int'(active_cfg) > NUM_SERVERS) ? NUM_SERVERS : int'(active_cfg);
			if ($urandom_range(99) < 8) begin
				op = $urandom_range(1);
				arr = $urandom;
				svc = $urandom;
			end else begin
				if (busy_n == 0)
					op = OP_ARRIVAL;
				else if (busy_n < up_n)
					op = ($urandom_range(99) < 60) ? OP_ARRIVAL : OP_DEPARTURE;
				else
					op = ($urandom_range(99) < 45) ? OP_ARRIVAL : OP_DEPARTURE;
				// Restart near zero once the clock has run up to the top.
				base = (now_ticks > 32'hFFFF_0000) ? 32'd0 : now_ticks;
				arr = base + $urandom_range(0, 60);
				svc = ($urandom_range(15) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 250);
			end
			if (!(op == OP_DEPARTURE && busy_n == 0))
				counted++;
			send_event(op, arr, svc);
		end
	endtask

	// Random traffic under one idle pattern, at two server counts.
	task automatic test_traffic(int send_pct, int recv_pct, bit [ACTIVE_W-1:0] first_cfg,
	                            int first_n, bit [ACTIVE_W-1:0] second_cfg, int second_n);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		write_active(first_cfg);
		run_traffic(first_n);
		write_active(second_cfg);
		run_traffic(second_n);
	endtask

	// Long output stall while words keep coming, so the input backs up.
	task automatic test_output_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_len = 400;
		run_traffic(16);
		quiesce();
		run_traffic(8);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_events();
		test_server_count_changes();
		test_traffic(10, 73, 6'd10, 200, 6'd63, 200);
		test_traffic(73, 10, 6'd1, 200, 6'd32, 200);
		test_traffic(0, 0, 6'd0, 30, 6'd20, 300);
		test_output_backpressure();
		quiesce();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && awaited_reports.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
